[design/mqttd_pkg.sv]
// Package for the MQTT packet deframer: parser phase codes, byte role codes
// and the result beat structure. No dependencies.
`default_nettype none

package mqttd_pkg;

    localparam int PhaseW = 4;
    localparam int RoleW  = 3;
    localparam int LenW   = 28;
    localparam int TopicW = 16;

    localparam logic [PhaseW-1:0] PH_HDR     = 4'd0;
    localparam logic [PhaseW-1:0] PH_LEN     = 4'd1;
    localparam logic [PhaseW-1:0] PH_TLEN_HI = 4'd2;
    localparam logic [PhaseW-1:0] PH_TLEN_LO = 4'd3;
    localparam logic [PhaseW-1:0] PH_TOPIC   = 4'd4;
    localparam logic [PhaseW-1:0] PH_PID_HI  = 4'd5;
    localparam logic [PhaseW-1:0] PH_PID_LO  = 4'd6;
    localparam logic [PhaseW-1:0] PH_PAYLOAD = 4'd7;
    localparam logic [PhaseW-1:0] PH_BODY    = 4'd8;
    localparam logic [PhaseW-1:0] PH_DISCARD = 4'd9;

    localparam logic [RoleW-1:0] ROLE_HDR     = 3'd0;
    localparam logic [RoleW-1:0] ROLE_LEN     = 3'd1;
    localparam logic [RoleW-1:0] ROLE_TLEN    = 3'd2;
    localparam logic [RoleW-1:0] ROLE_TOPIC   = 3'd3;
    localparam logic [RoleW-1:0] ROLE_PID     = 3'd4;
    localparam logic [RoleW-1:0] ROLE_PAYLOAD = 3'd5;
    localparam logic [RoleW-1:0] ROLE_BODY    = 3'd6;
    localparam logic [RoleW-1:0] ROLE_DISCARD = 3'd7;

    localparam logic [3:0] TYPE_PUBLISH = 4'h3;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic [RoleW-1:0] byte_role;
        logic [3:0]       packet_type;
        logic             qos_nonzero;
        logic             last_of_packet;
        logic             length_error;
        logic             topic_error;
    } mqttd_result_t;

endpackage

`default_nettype wire

[design/mqttd_stream_if.sv]
// Stream channels of the MQTT packet deframer: byte input and labeled result.
// Depends on mqttd_pkg for the role width.
`default_nettype none

interface mqttd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mqttd_out_if import mqttd_pkg::*;;
    logic             valid;
    logic             ready;
    logic [7:0]       data_byte;
    logic [RoleW-1:0] byte_role;
    logic [3:0]       packet_type;
    logic             qos_nonzero;
    logic             last_of_packet;
    logic             length_error;
    logic             topic_error;

    modport source (output valid, output data_byte, output byte_role, output packet_type,
                    output qos_nonzero, output last_of_packet, output length_error,
                    output topic_error, input ready);
    modport sink   (input valid, input data_byte, input byte_role, input packet_type,
                    input qos_nonzero, input last_of_packet, input length_error,
                    input topic_error, output ready);
endinterface

`default_nettype wire

[design/mqttd_parser.sv]
// Parser state and per-byte labeling logic of the MQTT packet deframer.
// Depends on mqttd_pkg.
`default_nettype none

module mqttd_parser import mqttd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          take,
    input  wire logic [7:0]    rx_byte,
    output mqttd_result_t      result
);

    logic [PhaseW-1:0] phase_reg, phase_next;
    logic [LenW-1:0]   body_left_reg, body_left_next;
    logic [1:0]        length_index_reg, length_index_next;
    logic [LenW-1:0]   length_shift_value_reg, length_shift_value_next;
    logic [TopicW-1:0] topic_left_reg, topic_left_next;
    logic [7:0]        topic_len_high_reg, topic_len_high_next;
    logic [3:0]        current_type_reg, current_type_next;
    logic              current_qos_reg, current_qos_next;

    logic [LenW-1:0]   body_dec;
    logic              body_done;
    logic [TopicW-1:0] topic_dec;
    logic [LenW-1:0]   len_part;
    logic [LenW-1:0]   len_acc;
    logic [TopicW-1:0] tlen;
    logic [PhaseW-1:0] after_topic;
    logic              is_publish;

    logic [RoleW-1:0]  role;
    logic              last;
    logic              lerr;
    logic              terr;

    always_comb
    begin
        body_dec  = (body_left_reg != '0) ? body_left_reg - 1'b1 : body_left_reg;
        body_done = (body_dec == '0);
        topic_dec = (topic_left_reg != '0) ? topic_left_reg - 1'b1 : topic_left_reg;
        case (length_index_reg)
            2'd0:    len_part = {21'b0, rx_byte[6:0]};
            2'd1:    len_part = {14'b0, rx_byte[6:0], 7'b0};
            2'd2:    len_part = {7'b0, rx_byte[6:0], 14'b0};
            default: len_part = {rx_byte[6:0], 21'b0};
        endcase
        len_acc     = length_shift_value_reg | len_part;
        tlen        = {topic_len_high_reg, rx_byte};
        is_publish  = (current_type_reg == TYPE_PUBLISH);
        // packet id only when it fits in what is left of the body
        after_topic = (current_qos_reg && body_dec >= LenW'(2)) ? PH_PID_HI : PH_PAYLOAD;
    end

    always_comb
    begin
        phase_next              = phase_reg;
        body_left_next          = body_left_reg;
        length_index_next       = length_index_reg;
        length_shift_value_next = length_shift_value_reg;
        topic_left_next         = topic_left_reg;
        topic_len_high_next     = topic_len_high_reg;
        current_type_next       = current_type_reg;
        current_qos_next        = current_qos_reg;
        role = ROLE_DISCARD;
        last = 1'b0;
        lerr = 1'b0;
        terr = 1'b0;

        unique case (phase_reg)
            PH_LEN:
            begin
                role = ROLE_LEN;
                length_shift_value_next = len_acc;
                if (!rx_byte[7])
                begin
                    body_left_next = len_acc;
                    if (is_publish && len_acc < LenW'(2))
                    begin
                        terr = 1'b1;
                        if (len_acc == '0)
                        begin
                            last       = 1'b1;
                            phase_next = PH_HDR;
                        end
                        else
                        begin
                            phase_next = PH_DISCARD;
                        end
                    end
                    else if (len_acc == '0)
                    begin
                        last       = 1'b1;
                        phase_next = PH_HDR;
                    end
                    else
                    begin
                        phase_next = is_publish ? PH_TLEN_HI : PH_BODY;
                    end
                end
                else if (length_index_reg == 2'd3)
                begin
                    lerr           = 1'b1;
                    last           = 1'b1;
                    body_left_next = '0;
                    phase_next     = PH_HDR;
                end
                else
                begin
                    length_index_next = length_index_reg + 1'b1;
                end
            end
            PH_TLEN_HI:
            begin
                role                = ROLE_TLEN;
                topic_len_high_next = rx_byte;
                body_left_next      = body_dec;
                if (body_done)
                begin
                    last       = 1'b1;
                    phase_next = PH_HDR;
                end
                else
                begin
                    phase_next = PH_TLEN_LO;
                end
            end
            PH_TLEN_LO:
            begin
                role           = ROLE_TLEN;
                body_left_next = body_dec;
                if (body_done)
                begin
                    last       = 1'b1;
                    phase_next = PH_HDR;
                    terr       = (tlen != '0);
                end
                else if ({12'b0, tlen} > body_dec)
                begin
                    terr       = 1'b1;
                    phase_next = PH_DISCARD;
                end
                else
                begin
                    topic_left_next = tlen;
                    phase_next      = (tlen != '0) ? PH_TOPIC : after_topic;
                end
            end
            PH_TOPIC:
            begin
                role            = ROLE_TOPIC;
                topic_left_next = topic_dec;
                body_left_next  = body_dec;
                if (body_done)
                begin
                    last       = 1'b1;
                    phase_next = PH_HDR;
                end
                else if (topic_dec == '0)
                begin
                    phase_next = after_topic;
                end
            end
            PH_PID_HI, PH_PID_LO, PH_PAYLOAD, PH_BODY, PH_DISCARD:
            begin
                case (phase_reg)
                    PH_PID_HI, PH_PID_LO: role = ROLE_PID;
                    PH_PAYLOAD:           role = ROLE_PAYLOAD;
                    PH_BODY:              role = ROLE_BODY;
                    default:              role = ROLE_DISCARD;
                endcase
                body_left_next = body_dec;
                if (body_done)
                begin
                    last       = 1'b1;
                    phase_next = PH_HDR;
                end
                else if (phase_reg == PH_PID_HI)
                begin
                    phase_next = PH_PID_LO;
                end
                else if (phase_reg == PH_PID_LO)
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
            default:
            begin
                // fixed header; unused phase codes land here too
                role                    = ROLE_HDR;
                current_type_next       = rx_byte[7:4];
                current_qos_next        = (rx_byte[2:1] != 2'b00);
                length_index_next       = '0;
                length_shift_value_next = '0;
                body_left_next          = '0;
                topic_left_next         = '0;
                topic_len_high_next     = '0;
                phase_next              = PH_LEN;
            end
        endcase

        result.data_byte      = rx_byte;
        result.byte_role      = role;
        result.packet_type    = current_type_next;
        result.qos_nonzero    = current_qos_next;
        result.last_of_packet = last;
        result.length_error   = lerr;
        result.topic_error    = terr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg              <= PH_HDR;
            body_left_reg          <= '0;
            length_index_reg       <= '0;
            length_shift_value_reg <= '0;
            topic_left_reg         <= '0;
            topic_len_high_reg     <= '0;
            current_type_reg       <= '0;
            current_qos_reg        <= 1'b0;
        end
        else if (take)
        begin
            phase_reg              <= phase_next;
            body_left_reg          <= body_left_next;
            length_index_reg       <= length_index_next;
            length_shift_value_reg <= length_shift_value_next;
            topic_left_reg         <= topic_left_next;
            topic_len_high_reg     <= topic_len_high_next;
            current_type_reg       <= current_type_next;
            current_qos_reg        <= current_qos_next;
        end
    end

endmodule

`default_nettype wire

[design/mqttd_out_buffer.sv]
// Two-entry output register with skid stage for deframer result beats.
// Depends on mqttd_pkg and mqttd_out_if.
`default_nettype none

module mqttd_out_buffer import mqttd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire mqttd_result_t push_data,
    output logic               can_push,
    mqttd_out_if.source        tx
);

    logic          out_valid_reg;
    logic          skid_valid_reg;
    mqttd_result_t out_data_reg;
    mqttd_result_t skid_data_reg;
    logic          pop;
    logic          out_free;

    assign pop      = out_valid_reg && tx.ready;
    assign out_free = !out_valid_reg || pop;
    assign can_push = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign tx.valid          = out_valid_reg;
    assign tx.data_byte      = out_data_reg.data_byte;
    assign tx.byte_role      = out_data_reg.byte_role;
    assign tx.packet_type    = out_data_reg.packet_type;
    assign tx.qos_nonzero    = out_data_reg.qos_nonzero;
    assign tx.last_of_packet = out_data_reg.last_of_packet;
    assign tx.length_error   = out_data_reg.length_error;
    assign tx.topic_error    = out_data_reg.topic_error;

endmodule

`default_nettype wire

[design/mqttd_top.sv]
// MQTT 3.1.1 packet deframer. Byte stream in on rx, one labeled result beat
// out on tx for every byte taken in.
//
// Usage:
//  - rx carries one received byte per beat (valid/ready). tx carries the
//    byte back with its role, packet type, QoS flag, end-of-packet flag and
//    the length and topic error flags.
//  - Each byte is labeled in the cycle it is accepted and its result beat
//    is registered in the output stage, or in the skid entry if tx stalls.
//  - Throughput is one byte per cycle while tx takes its beats; the per-byte
//    step is a single update of the phase register and the length/topic counters.
//  - When tx stalls, a skid entry holds one more result, so rx can accept
//    one more byte; rx.ready then drops until tx drains.
//  - Reset (rst_n low, asynchronous) empties the output stages and puts the
//    parser back to expecting a fixed header with all counters cleared.
//  - Results come out in input order, one per byte, none dropped.
// Depends on mqttd_pkg, mqttd_stream_if, mqttd_parser, mqttd_out_buffer.
`default_nettype none

module mqtt_packet_deframer_top import mqttd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    mqttd_in_if.sink    rx,
    mqttd_out_if.source tx
);

    logic          take;
    logic          can_push;
    mqttd_result_t result;

    assign rx.ready = can_push;
    assign take     = rx.valid && can_push;

    mqttd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .rx_byte (rx.rx_byte),
        .result  (result)
    );

    mqttd_out_buffer u_out_buffer (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .push_data (result),
        .can_push  (can_push),
        .tx        (tx)
    );

endmodule

`default_nettype wire
